>>> rtl/sfla_pkg.sv
// Shared constants, types and codes of the segregated free list allocator.
`default_nettype none
package sfla_pkg;
	localparam int ALIGN_BYTES     = 8;
	localparam int ALIGN_LOG2      = $clog2(ALIGN_BYTES);
	localparam int MAX_SMALL_BYTES = 128;
	localparam int NUM_CLASSES     = 16;
	localparam int CLS_W           = $clog2(NUM_CLASSES);
	localparam int REFILL_COUNT    = 20;
	localparam int CNT_W           = $clog2(REFILL_COUNT + 1);
	localparam int ARENA_BYTES     = 65536;
	localparam int ADDR_W          = 16;
	localparam int SIZE_W          = 12;
	localparam int PTR_W           = 17;
	localparam int LINK_DEPTH      = ARENA_BYTES / ALIGN_BYTES;
	localparam int LINK_AW         = $clog2(LINK_DEPTH);
	localparam int BLK_W           = $clog2(MAX_SMALL_BYTES + 1);

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_OVERSIZE = 2'd1;
	localparam logic [1:0] ST_OOM      = 2'd2;

	typedef struct packed {
		logic              valid;
		logic [ADDR_W-1:0] addr;
	} link_t;

	typedef struct packed {
		logic             en;
		logic [CLS_W-1:0] idx;
		link_t            ent;
	} hd_wr_t;

	typedef struct packed {
		logic              found;
		logic [CLS_W-1:0]  idx;
		logic [ADDR_W-1:0] addr;
	} hd_srch_t;
endpackage
`default_nettype wire

>>> rtl/sfla_if.sv
// Request and response channel interfaces of the allocator.
`default_nettype none
interface sfla_req_if;
	logic        valid;
	logic        ready;
	logic        mode;
	logic [11:0] size_bytes;
	logic [15:0] block_address;
	modport source(output valid, mode, size_bytes, block_address, input ready);
	modport sink(input valid, mode, size_bytes, block_address, output ready);
endinterface

interface sfla_rsp_if;
	logic        valid;
	logic        ready;
	logic [15:0] address;
	logic [1:0]  status;
	modport source(output valid, address, status, input ready);
	modport sink(input valid, address, status, output ready);
endinterface
`default_nettype wire

>>> rtl/sfla_link_ram.sv
// Link store: next-block pointer per arena slot, one write and one registered read port.
`default_nettype none
module sfla_link_ram (
	input  wire logic                        clk,
	input  wire logic                        we,
	input  wire logic [sfla_pkg::LINK_AW-1:0] waddr,
	input  wire sfla_pkg::link_t             wdata,
	input  wire logic [sfla_pkg::LINK_AW-1:0] raddr,
	output sfla_pkg::link_t                  rdata
);
	sfla_pkg::link_t mem [sfla_pkg::LINK_DEPTH];
	sfla_pkg::link_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;
endmodule
`default_nettype wire

>>> rtl/sfla_heads.sv
// Class list heads with valid bits, a read port and an upward search for a free block.
`default_nettype none
module sfla_heads (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire sfla_pkg::hd_wr_t          wr,
	input  wire logic [sfla_pkg::CLS_W-1:0] rd_idx,
	output sfla_pkg::link_t                rd,
	input  wire logic [sfla_pkg::CLS_W-1:0] base,
	output sfla_pkg::hd_srch_t             srch
);
	logic [sfla_pkg::NUM_CLASSES-1:0] valid_q;
	logic [sfla_pkg::ADDR_W-1:0]      addr_q [sfla_pkg::NUM_CLASSES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr.en) begin
			valid_q[wr.idx] <= wr.ent.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en) begin
			addr_q[wr.idx] <= wr.ent.addr;
		end
	end

	assign rd.valid = valid_q[rd_idx];
	assign rd.addr  = addr_q[rd_idx];

	always_comb begin
		srch = '0;
		for (int k = 0; k < sfla_pkg::NUM_CLASSES; k++) begin
			if (!srch.found && (k >= int'(base)) && valid_q[k]) begin
				srch.found = 1'b1;
				srch.idx   = sfla_pkg::CLS_W'(k);
				srch.addr  = addr_q[k];
			end
		end
	end
endmodule
`default_nettype wire

>>> rtl/segregated_free_list_allocator.sv
// Top level of the segregated free list allocator: request sequencer, pool registers, output register.
// One request at a time. A free or an oversize request passes the dispatch state only, a list hit also
// the pop state; a miss carves from the pool at one link store write per cycle (grow or borrow first,
// then the carved blocks, REFILL_COUNT at most). The link store has one write and one read port with a
// registered read, which sets the pace. A new request is taken once the previous result is placed in
// the output register; the result waits there until taken.
`default_nettype none
module segregated_free_list_allocator (
	input  wire logic clk,
	input  wire logic arst_n,
	sfla_req_if.sink   req,
	sfla_rsp_if.source rsp
);
	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_DISP   = 3'd1;
	localparam logic [2:0] S_POPW   = 3'd2;
	localparam logic [2:0] S_REFILL = 3'd3;
	localparam logic [2:0] S_SEARCH = 3'd4;
	localparam logic [2:0] S_BORW   = 3'd5;
	localparam logic [2:0] S_CARVE  = 3'd6;
	localparam logic [2:0] S_FIN    = 3'd7;

	localparam int PW = sfla_pkg::PTR_W;
	localparam int AW = sfla_pkg::ADDR_W;
	localparam int CW = sfla_pkg::CLS_W;
	localparam logic [PW:0] ARENA = (PW+1)'(sfla_pkg::ARENA_BYTES);

	logic [2:0]                      state_q;
	logic                            mode_q;
	logic                            oversize_q;
	logic [CW-1:0]                   cls_q;
	logic [sfla_pkg::BLK_W-1:0]      blk_q;
	logic [AW-1:0]                   baddr_q;
	logic [PW-1:0]                   res_q;
	logic [1:0]                      status_q;
	logic [PW-1:0]                   pstart_q, pend_q, atop_q, htotal_q;
	logic [sfla_pkg::CNT_W-1:0]      i_q;
	logic [PW-1:0]                   off_q;
	logic [CW-1:0]                   k_q;
	logic                            out_valid_q;
	logic [AW-1:0]                   out_addr_q;
	logic [1:0]                      out_status_q;

	sfla_pkg::hd_wr_t   hd_wr;
	sfla_pkg::link_t    hd_rd;
	logic [CW-1:0]      hd_rd_idx;
	sfla_pkg::hd_srch_t srch;

	logic                          lk_we;
	logic [sfla_pkg::LINK_AW-1:0]  lk_waddr, lk_raddr;
	sfla_pkg::link_t               lk_wdata, lk_rdata;

	sfla_heads u_heads (
		.clk(clk), .arst_n(arst_n), .wr(hd_wr), .rd_idx(hd_rd_idx), .rd(hd_rd),
		.base(cls_q), .srch(srch)
	);

	sfla_link_ram u_link (
		.clk(clk), .we(lk_we), .waddr(lk_waddr), .wdata(lk_wdata),
		.raddr(lk_raddr), .rdata(lk_rdata)
	);

	// request decode
	logic [sfla_pkg::SIZE_W:0] sz;
	logic [sfla_pkg::SIZE_W:0] cls_full;
	logic                      in_oversize;
	always_comb begin
		sz = (req.size_bytes == '0) ? (sfla_pkg::SIZE_W+1)'(sfla_pkg::ALIGN_BYTES)
			: {1'b0, req.size_bytes};
		cls_full = ((sz + (sfla_pkg::SIZE_W+1)'(sfla_pkg::ALIGN_BYTES - 1))
			>> sfla_pkg::ALIGN_LOG2) - 1'b1;
		in_oversize = (sz > (sfla_pkg::SIZE_W+1)'(sfla_pkg::MAX_SMALL_BYTES))
			|| (cls_full >= (sfla_pkg::SIZE_W+1)'(sfla_pkg::NUM_CLASSES));
	end

	// pool arithmetic
	logic [PW-1:0] left, blk_w, want, qr, lo_raw, b, b_nxt;
	logic [PW:0]   get, grow_end;
	logic          fit, lo_push, exists, nxt_ok, b_in;
	logic [CW-1:0] lo_cls;
	always_comb begin
		left     = pend_q - pstart_q;
		blk_w    = PW'(blk_q);
		want     = PW'(blk_w * PW'(sfla_pkg::REFILL_COUNT));
		qr       = ((htotal_q >> 4) + PW'(sfla_pkg::ALIGN_BYTES - 1))
			& ~PW'(sfla_pkg::ALIGN_BYTES - 1);
		get      = {want, 1'b0} + {1'b0, qr};
		grow_end = {1'b0, atop_q} + get;
		fit      = grow_end <= ARENA;
		lo_raw   = left >> sfla_pkg::ALIGN_LOG2;
		lo_push  = (lo_raw != '0) && (lo_raw <= PW'(sfla_pkg::NUM_CLASSES))
			&& ({1'b0, pstart_q} < ARENA);
		lo_cls   = CW'(lo_raw - 1'b1);
		b        = res_q + off_q;
		b_nxt    = b + blk_w;
		b_in     = {1'b0, b} < ARENA;
		exists   = (i_q < sfla_pkg::CNT_W'(sfla_pkg::REFILL_COUNT))
			&& ({1'b0, off_q} + {1'b0, blk_w} <= {1'b0, left});
		nxt_ok   = (i_q + 1'b1 < sfla_pkg::CNT_W'(sfla_pkg::REFILL_COUNT))
			&& ({1'b0, off_q} + {blk_w, 1'b0} <= {1'b0, left})
			&& ({1'b0, b_nxt} < ARENA);
	end

	assign hd_rd_idx = (state_q == S_REFILL) ? lo_cls : cls_q;
	assign req.ready = (state_q == S_IDLE);

	always_comb begin
		hd_wr    = '0;
		lk_we    = 1'b0;
		lk_waddr = '0;
		lk_wdata = '0;
		lk_raddr = '0;
		unique case (state_q)
			S_DISP: begin
				if (!oversize_q && mode_q) begin
					lk_we      = 1'b1;
					lk_waddr   = baddr_q[AW-1:sfla_pkg::ALIGN_LOG2];
					lk_wdata   = hd_rd;
					hd_wr.en   = 1'b1;
					hd_wr.idx  = cls_q;
					hd_wr.ent  = '{valid: 1'b1,
						addr: {baddr_q[AW-1:sfla_pkg::ALIGN_LOG2], {sfla_pkg::ALIGN_LOG2{1'b0}}}};
				end
				lk_raddr = hd_rd.addr[AW-1:sfla_pkg::ALIGN_LOG2];
			end
			S_POPW: begin
				hd_wr = '{en: 1'b1, idx: cls_q, ent: lk_rdata};
			end
			S_REFILL: begin
				if ((left < blk_w) && lo_push) begin
					lk_we     = 1'b1;
					lk_waddr  = pstart_q[AW-1:sfla_pkg::ALIGN_LOG2];
					lk_wdata  = hd_rd;
					hd_wr.en  = 1'b1;
					hd_wr.idx = lo_cls;
					hd_wr.ent = '{valid: 1'b1, addr: pstart_q[AW-1:0]};
				end
			end
			S_SEARCH: begin
				lk_raddr = srch.addr[AW-1:sfla_pkg::ALIGN_LOG2];
			end
			S_BORW: begin
				hd_wr = '{en: 1'b1, idx: k_q, ent: lk_rdata};
			end
			S_CARVE: begin
				if (exists) begin
					lk_we    = b_in;
					lk_waddr = b[AW-1:sfla_pkg::ALIGN_LOG2];
					lk_wdata = '{valid: nxt_ok, addr: b_nxt[AW-1:0]};
					if (i_q == sfla_pkg::CNT_W'(1)) begin
						hd_wr = '{en: 1'b1, idx: cls_q, ent: '{valid: b_in, addr: b[AW-1:0]}};
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pstart_q    <= '0;
			pend_q      <= '0;
			atop_q      <= '0;
			htotal_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_FIN && (!out_valid_q || rsp.ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						state_q <= S_DISP;
					end
				end
				S_DISP: begin
					if (oversize_q || mode_q) begin
						state_q <= S_FIN;
					end else if (hd_rd.valid) begin
						state_q <= S_POPW;
					end else begin
						state_q <= S_REFILL;
					end
				end
				S_POPW: state_q <= S_FIN;
				S_REFILL: begin
					if (left >= blk_w) begin
						state_q <= S_CARVE;
					end else if (fit) begin
						pstart_q <= atop_q;
						atop_q   <= PW'(grow_end);
						pend_q   <= PW'(grow_end);
						htotal_q <= PW'({1'b0, htotal_q} + get);
					end else begin
						pstart_q <= pend_q;
						state_q  <= S_SEARCH;
					end
				end
				S_SEARCH: begin
					if (srch.found) begin
						pstart_q <= PW'(srch.addr);
						pend_q   <= PW'(srch.addr)
							+ (PW'(PW'(srch.idx) + 1'b1) << sfla_pkg::ALIGN_LOG2);
						state_q  <= S_BORW;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_BORW: state_q <= S_REFILL;
				S_CARVE: begin
					if (!exists) begin
						pstart_q <= res_q + off_q;
						state_q  <= S_FIN;
					end
				end
				S_FIN: begin
					if (!out_valid_q || rsp.ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				mode_q     <= req.mode;
				oversize_q <= in_oversize;
				cls_q      <= CW'(cls_full);
				blk_q      <= sfla_pkg::BLK_W'((cls_full + 1'b1) << sfla_pkg::ALIGN_LOG2);
				baddr_q    <= req.block_address;
				res_q      <= '0;
				status_q   <= in_oversize ? sfla_pkg::ST_OVERSIZE : sfla_pkg::ST_OK;
			end
			S_DISP: begin
				if (!oversize_q && !mode_q && hd_rd.valid) begin
					res_q <= PW'(hd_rd.addr);
				end
			end
			S_REFILL: begin
				res_q <= pstart_q;
				i_q   <= sfla_pkg::CNT_W'(1);
				off_q <= blk_w;
			end
			S_SEARCH: begin
				k_q <= srch.idx;
				if (!srch.found) begin
					res_q    <= '0;
					status_q <= sfla_pkg::ST_OOM;
				end
			end
			S_CARVE: begin
				i_q   <= i_q + 1'b1;
				off_q <= off_q + blk_w;
			end
			S_FIN: begin
				if (!out_valid_q || rsp.ready) begin
					out_addr_q   <= res_q[AW-1:0];
					out_status_q <= status_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign rsp.valid   = out_valid_q;
	assign rsp.address = out_addr_q;
	assign rsp.status  = out_status_q;

	a_pool_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_SEARCH && state_q != S_BORW) |-> pstart_q <= pend_q)
		else $error("pool start beyond pool end");
	a_arena_bound: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, atop_q} <= ARENA && htotal_q == atop_q)
		else $error("arena top out of bounds or heap total mismatch");
	a_oom_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status == sfla_pkg::ST_OOM) |-> rsp.address == '0)
		else $error("out of memory result with nonzero address");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("second item taken while busy");
endmodule
`default_nettype wire

>>> bench/tb_segregated_free_list_allocator.sv
// Self-checking testbench of the segregated free list allocator with a built-in allocator predictor.
`default_nettype none
module tb_segregated_free_list_allocator;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic MODE_ALLOC = 1'b0;
	localparam logic MODE_FREE  = 1'b1;
	localparam int   STALL_LIMIT = 5000;

	typedef struct {
		logic        mode;
		logic [11:0] size_bytes;
		logic [15:0] block_address;
	} request_t;

	typedef struct {
		logic        mode;
		logic [11:0] size_bytes;
		logic [15:0] address;
		logic [1:0]  status;
	} grant_t;

	typedef struct {
		bit          valid;
		int unsigned addr;
	} slot_t;

	logic clk = 1'b0;
	logic arst_n;
	sfla_req_if req();
	sfla_rsp_if rsp();

	segregated_free_list_allocator dut (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp));

	always #6 clk = ~clk;

	request_t    pending_reqs[$];
	grant_t      expected_grants[$];
	grant_t      live_blocks[$];
	int          send_idle_pct;
	int          recv_stall_pct;
	int          fail_count;
	int          quiet_cycles;

	slot_t       heads[sfla_pkg::NUM_CLASSES];
	slot_t       links[sfla_pkg::LINK_DEPTH];
	int unsigned pool_lo, pool_hi, top_addr, grown_bytes;

	function automatic void push_free(int unsigned cls, int unsigned a);
		int unsigned i;
		i = a / sfla_pkg::ALIGN_BYTES;
		if (cls >= sfla_pkg::NUM_CLASSES || i >= sfla_pkg::LINK_DEPTH)
			return;
		links[i] = heads[cls];
		heads[cls].valid = 1'b1;
		heads[cls].addr = a;
	endfunction

	function automatic bit pop_free(int unsigned cls, output int unsigned a);
		int unsigned i;
		a = 0;
		if (cls >= sfla_pkg::NUM_CLASSES || !heads[cls].valid)
			return 1'b0;
		a = heads[cls].addr;
		i = a / sfla_pkg::ALIGN_BYTES;
		if (i < sfla_pkg::LINK_DEPTH)
			heads[cls] = links[i];
		else
			heads[cls].valid = 1'b0;
		return 1'b1;
	endfunction

	function automatic bit carve_pool(int unsigned cls, int unsigned blk, output int unsigned first);
		int unsigned want, left, n, a, q, grab;
		bit found;
		first = 0;
		want = blk * sfla_pkg::REFILL_COUNT;
		left = pool_hi - pool_lo;
		if (left < blk) begin
			q = grown_bytes >> 4;
			grab = 2 * want + ((q + sfla_pkg::ALIGN_BYTES - 1) / sfla_pkg::ALIGN_BYTES)
				* sfla_pkg::ALIGN_BYTES;
			if (left / sfla_pkg::ALIGN_BYTES >= 1)
				push_free(left / sfla_pkg::ALIGN_BYTES - 1, pool_lo);
			pool_lo = pool_hi;
			if (longint'(top_addr) + grab <= sfla_pkg::ARENA_BYTES) begin
				pool_lo = top_addr;
				top_addr += grab;
				pool_hi = top_addr;
				grown_bytes += grab;
			end else begin
				found = 1'b0;
				for (int unsigned k = cls; k < sfla_pkg::NUM_CLASSES && !found; k++) begin
					if (pop_free(k, a)) begin
						pool_lo = a;
						pool_hi = a + (k + 1) * sfla_pkg::ALIGN_BYTES;
						found = 1'b1;
					end
				end
				if (!found)
					return 1'b0;
			end
			left = pool_hi - pool_lo;
		end
		n = (left >= want) ? sfla_pkg::REFILL_COUNT : left / blk;
		first = pool_lo;
		pool_lo += n * blk;
		if (n > 1) begin
			heads[cls].valid = 1'b0;
			heads[cls].addr = 0;
			for (int i = n - 1; i >= 1; i--)
				push_free(cls, first + i * blk);
		end
		return 1'b1;
	endfunction

	function automatic grant_t predict_grant(request_t r);
		grant_t g;
		int unsigned size, cls, a;
		g.mode = r.mode;
		g.size_bytes = r.size_bytes;
		g.address = '0;
		g.status = sfla_pkg::ST_OK;
		a = 0;
		size = (r.size_bytes == 0) ? sfla_pkg::ALIGN_BYTES : r.size_bytes;
		cls = (size + sfla_pkg::ALIGN_BYTES - 1) / sfla_pkg::ALIGN_BYTES - 1;
		if (size > sfla_pkg::MAX_SMALL_BYTES || cls >= sfla_pkg::NUM_CLASSES)
			g.status = sfla_pkg::ST_OVERSIZE;
		else if (r.mode == MODE_FREE)
			push_free(cls, r.block_address - r.block_address % sfla_pkg::ALIGN_BYTES);
		else if (!pop_free(cls, a)) begin
			if (!carve_pool(cls, (cls + 1) * sfla_pkg::ALIGN_BYTES, a)) begin
				a = 0;
				g.status = sfla_pkg::ST_OOM;
			end
		end
		g.address = a[15:0];
		return g;
	endfunction

	function automatic request_t make_req(logic m, int unsigned sz, int unsigned ad);
		request_t r;
		r.mode = m;
		r.size_bytes = sz[11:0];
		r.block_address = ad[15:0];
		return r;
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req.valid <= 1'b0;
		end else if (!req.valid || req.ready) begin
			if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				req.valid <= 1'b1;
				req.mode <= pending_reqs[0].mode;
				req.size_bytes <= pending_reqs[0].size_bytes;
				req.block_address <= pending_reqs[0].block_address;
				void'(pending_reqs.pop_front());
			end else begin
				req.valid <= 1'b0;
			end
		end
	end

	// receiver and checker
	always @(posedge clk or negedge arst_n) begin
		grant_t e;
		if (!arst_n) begin
			rsp.ready <= 1'b0;
			quiet_cycles <= 0;
		end else begin
			rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (req.valid && req.ready)
				expected_grants.push_back(predict_grant(make_req(req.mode, req.size_bytes,
					req.block_address)));
			if (rsp.valid && rsp.ready) begin
				if (expected_grants.size() == 0) begin
					$error("unexpected result: address %0h status %0d", rsp.address, rsp.status);
					fail_count++;
				end else begin
					e = expected_grants.pop_front();
					if (rsp.address !== e.address) begin
						$error("address: expected %0h actual %0h", e.address, rsp.address);
						fail_count++;
					end
					if (rsp.status !== e.status) begin
						$error("status: expected %0d actual %0d", e.status, rsp.status);
						fail_count++;
					end
					if (e.mode == MODE_ALLOC && e.status == sfla_pkg::ST_OK)
						live_blocks.push_back(e);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	task automatic wait_drained();
		while (pending_reqs.size() > 0 || req.valid || expected_grants.size() > 0)
			@(posedge clk);
	endtask

	task automatic add_random(int count);
		int r, k;
		grant_t b;
		repeat (count) begin
			r = $urandom_range(99);
			if (r < 55) begin
				if ($urandom_range(3) == 0)
					pending_reqs.push_back(make_req(MODE_ALLOC, $urandom_range(0, 128), $urandom));
				else
					pending_reqs.push_back(make_req(MODE_ALLOC, $urandom_range(0, 32), $urandom));
			end else if (r < 85 && live_blocks.size() > 0) begin
				k = $urandom_range(live_blocks.size() - 1);
				b = live_blocks[k];
				live_blocks.delete(k);
				pending_reqs.push_back(make_req(MODE_FREE, b.size_bytes,
					b.address + $urandom_range(sfla_pkg::ALIGN_BYTES - 1)));
			end else if (r < 93) begin
				pending_reqs.push_back(make_req(MODE_FREE, $urandom_range(0, 128), $urandom));
			end else begin
				pending_reqs.push_back(make_req(($urandom_range(1) == 1) ? MODE_FREE : MODE_ALLOC,
					$urandom_range(129, 4095), $urandom));
			end
		end
	endtask

	initial begin
		int idle_set[4][2];
		idle_set = '{'{0, 0}, '{50, 0}, '{0, 50}, '{37, 37}};
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.mode = MODE_ALLOC;
		req.size_bytes = '0;
		req.block_address = '0;
		rsp.ready = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		fail_count = 0;
		for (int i = 0; i < sfla_pkg::NUM_CLASSES; i++)
			heads[i] = '{1'b0, 0};
		for (int i = 0; i < sfla_pkg::LINK_DEPTH; i++)
			links[i] = '{1'b0, 0};
		pool_lo = 0;
		pool_hi = 0;
		top_addr = 0;
		grown_bytes = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// directed: extremes, both modes, oversize, zero size, misaligned free
		pending_reqs.push_back(make_req(MODE_ALLOC, 0, 16'hFFFF));
		pending_reqs.push_back(make_req(MODE_ALLOC, 1, 0));
		pending_reqs.push_back(make_req(MODE_ALLOC, 8, 0));
		pending_reqs.push_back(make_req(MODE_ALLOC, 9, 0));
		pending_reqs.push_back(make_req(MODE_ALLOC, 128, 0));
		pending_reqs.push_back(make_req(MODE_ALLOC, 129, 0));
		pending_reqs.push_back(make_req(MODE_ALLOC, 4095, 16'hFFFF));
		pending_reqs.push_back(make_req(MODE_FREE, 4095, 16'hFFFF));
		pending_reqs.push_back(make_req(MODE_FREE, 8, 16'h0003));
		pending_reqs.push_back(make_req(MODE_FREE, 128, 16'hFFFF));
		pending_reqs.push_back(make_req(MODE_FREE, 0, 16'h8007));
		pending_reqs.push_back(make_req(MODE_ALLOC, 8, 0));
		pending_reqs.push_back(make_req(MODE_ALLOC, 128, 0));
		pending_reqs.push_back(make_req(MODE_ALLOC, 0, 0));
		pending_reqs.push_back(make_req(MODE_FREE, 8, 16'h0000));
		pending_reqs.push_back(make_req(MODE_FREE, 8, 16'h0000));
		pending_reqs.push_back(make_req(MODE_ALLOC, 8, 0));
		pending_reqs.push_back(make_req(MODE_ALLOC, 8, 0));
		wait_drained();

		for (int p = 0; p < 4; p++) begin
			send_idle_pct = idle_set[p][0];
			recv_stall_pct = idle_set[p][1];
			for (int c = 0; c < 23; c++) begin
				add_random(20);
				while (pending_reqs.size() > 4)
					@(posedge clk);
			end
			if (p == 1)
				wait_drained();
		end
		// drive the arena into exhaustion with large requests
		send_idle_pct = 0;
		recv_stall_pct = 0;
		for (int i = 0; i < 60; i++)
			pending_reqs.push_back(make_req(MODE_ALLOC, $urandom_range(96, 128), $urandom));
		wait_drained();
		repeat (40) @(posedge clk);
		if (fail_count == 0 && expected_grants.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule
`default_nettype wire

>>> filelist.f
rtl/sfla_pkg.sv
rtl/sfla_if.sv
rtl/sfla_link_ram.sv
rtl/sfla_heads.sv
rtl/segregated_free_list_allocator.sv
bench/tb_segregated_free_list_allocator.sv
